// ===== rtl/ahfe_pkg.sv =====
`default_nettype none

package ahfe_pkg;

  // Character codes of the frame.
  localparam logic [6:0] CHAR_SOF = 7'h7E;
  localparam logic [6:0] CHAR_CR  = 7'h0D;

  // Configuration register indexes.
  localparam logic [1:0] REG_VERSION = 2'd0;
  localparam logic [1:0] REG_ADDRESS = 2'd1;
  localparam logic [1:0] REG_CLASS   = 2'd2;

  // Character positions within one frame.
  localparam logic [4:0] STEP_SOF      = 5'd0;
  localparam logic [4:0] STEP_HDR_LAST = 5'd12;
  localparam logic [4:0] STEP_PB_HI    = 5'd13;
  localparam logic [4:0] STEP_PB_LO    = 5'd14;
  localparam logic [4:0] STEP_CHK_HI   = 5'd15;
  localparam logic [4:0] STEP_CHK_LO   = 5'd18;
  localparam logic [4:0] STEP_EOF      = 5'd19;

  // Reset value of the class code register.
  localparam logic [7:0] CLASS_RESET = 8'hD0;

  // Header bytes held by the configuration registers.
  typedef struct packed {
    logic [7:0] version;
    logic [7:0] address;
    logic [7:0] class_code;
  } cfg_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic        first;     // header goes out before this beat
    logic        has_byte;  // payload byte goes out
    logic        last;      // checksum and CR close the frame
    logic [7:0]  command;
    logic [15:0] len_word;
    logic [7:0]  pbyte;
  } entry_t;

  // Uppercase hex digit of a nibble.
  function automatic logic [6:0] hex_char(input logic [3:0] v);
    logic [6:0] c;
    if (v < 4'd10) c = 7'h30 + {3'b000, v};
    else           c = 7'h37 + {3'b000, v};
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ahfe_front.sv =====
`default_nettype none

module ahfe_front import ahfe_pkg::*; #(
  parameter int MAX_INFO_BYTES = 2047
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [7:0]  command,
  input  wire logic [10:0] info_length,
  input  wire logic [7:0]  payload_byte,
  output entry_t           entry
);

  localparam logic [10:0] MaxLen = 11'(MAX_INFO_BYTES);

  logic        in_frame_r, in_frame_nxt;
  logic [10:0] bytes_left_r, bytes_left_nxt;
  logic [10:0] len_sat;
  logic [11:0] lenid;
  logic [5:0]  nsum;
  logic [3:0]  check;
  logic [10:0] left;

  // Length word: twice the length under a negated nibble-sum check.
  assign len_sat = (info_length > MaxLen) ? MaxLen : info_length;
  assign lenid   = {len_sat, 1'b0};
  assign nsum    = {2'b00, lenid[3:0]} + {2'b00, lenid[7:4]} + {2'b00, lenid[11:8]};
  assign check   = 4'(6'd0 - nsum);

  // Classify the beat and track the position within the frame.
  always_comb begin
    entry.command  = command;
    entry.len_word = {check, lenid};
    entry.pbyte    = payload_byte;
    entry.first    = !in_frame_r;
    left           = 11'd0;
    if (!in_frame_r) begin
      if (len_sat == 11'd0) begin
        entry.has_byte = 1'b0;
      end else begin
        entry.has_byte = 1'b1;
        left           = len_sat - 11'd1;
      end
    end else begin
      entry.has_byte = 1'b1;
      left           = bytes_left_r - 11'd1;
    end
    entry.last     = (left == 11'd0);
    in_frame_nxt   = in_frame_r;
    bytes_left_nxt = bytes_left_r;
    if (acc) begin
      in_frame_nxt   = !entry.last;
      bytes_left_nxt = left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      bytes_left_r <= 11'd0;
    end else begin
      in_frame_r   <= in_frame_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ahfe_queue.sv =====
`default_nettype none

module ahfe_queue import ahfe_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  entry_t      push_data,
  output logic        full,
  input  wire logic   pop,
  output logic        not_empty,
  output entry_t      head
);

  entry_t     slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ahfe_back.sv =====
`default_nettype none

module ahfe_back import ahfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cfg_t             cfg,
  input  wire logic        q_valid,
  input  entry_t           q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_char,
  output logic             out_eof
);

  logic        active_r, active_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [6:0]  ochar_r;
  logic        oeof_r;
  logic [4:0]  cur;
  logic [3:0]  hidx;
  logic [1:0]  tsel;
  logic [7:0]  hbyte;
  logic [15:0] chk;
  logic [3:0]  nib;
  logic [6:0]  ch;
  logic        eof;
  logic        emit;
  logic        done;

  assign out_valid = ovalid_r;
  assign out_char  = ochar_r;
  assign out_eof   = oeof_r;

  // Position of the next character of the head entry.
  assign cur  = active_r ? step_r : (q_head.first ? STEP_SOF : STEP_PB_HI);
  assign emit = q_valid && (!ovalid_r || out_ready);
  assign hidx = 4'(cur - 5'd1);
  assign tsel = 2'(cur - STEP_CHK_HI);
  assign chk  = 16'h0000 - sum_r;

  // Header byte selected by the position.
  always_comb begin
    unique case (hidx[3:1])
      3'd0:    hbyte = cfg.version;
      3'd1:    hbyte = cfg.address;
      3'd2:    hbyte = cfg.class_code;
      3'd3:    hbyte = q_head.command;
      3'd4:    hbyte = q_head.len_word[15:8];
      3'd5:    hbyte = q_head.len_word[7:0];
      default: hbyte = 8'h00;
    endcase
  end

  // Character at the current position and the running sum.
  always_comb begin
    eof     = 1'b0;
    sum_nxt = sum_r;
    nib     = 4'h0;
    priority if (cur == STEP_SOF) begin
      ch = CHAR_SOF;
    end else if (cur <= STEP_HDR_LAST) begin
      nib = hidx[0] ? hbyte[3:0] : hbyte[7:4];
      ch  = hex_char(nib);
    end else if (cur <= STEP_PB_LO) begin
      nib = (cur == STEP_PB_LO) ? q_head.pbyte[3:0] : q_head.pbyte[7:4];
      ch  = hex_char(nib);
    end else if (cur <= STEP_CHK_LO) begin
      unique case (tsel)
        2'd0: nib = chk[15:12];
        2'd1: nib = chk[11:8];
        2'd2: nib = chk[7:4];
        2'd3: nib = chk[3:0];
      endcase
      ch = hex_char(nib);
    end else begin
      ch  = CHAR_CR;
      eof = 1'b1;
    end
    if (cur == STEP_SOF) begin
      sum_nxt = 16'h0000;
    end else if (cur <= STEP_PB_LO) begin
      sum_nxt = sum_r + {9'd0, ch};
    end
  end

  // Sequencing through the positions of one entry.
  always_comb begin
    done     = 1'b0;
    step_nxt = cur + 5'd1;
    if (cur == STEP_HDR_LAST && !q_head.has_byte) begin
      step_nxt = STEP_CHK_HI;
    end else if (cur == STEP_PB_LO && !q_head.last) begin
      done = 1'b1;
    end else if (cur == STEP_EOF) begin
      done = 1'b1;
    end
    q_pop      = emit && done;
    active_nxt = active_r;
    if (emit) begin
      active_nxt = !done;
    end
    ovalid_nxt = emit || (ovalid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Position, sum and output beat.
  always_ff @(posedge clk) begin
    if (emit) begin
      step_r  <= step_nxt;
      sum_r   <= sum_nxt;
      ochar_r <= ch;
      oeof_r  <= eof;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ascii_hex_frame_encoder_top.sv =====
`default_nettype none

// ASCII-hex frame encoder. The first input beat of a frame carries the command and
// payload length; the block sends '~', then version, address, class code,
// command and the checked length word as uppercase hex, then two hex characters
// per payload byte, then the four-digit negated character sum and CR, which is
// flagged with out_end_of_frame. One character leaves per cycle, unless stalled,
// through a single output register, so a payload beat yields two characters, the
// first beat of a frame fifteen (thirteen for a zero-length frame) and the closing
// beat five more for the trailer. A two-entry queue between input classification
// and the character sequencer lets input beats in while characters still drain.
// Configuration writes are always taken and must happen while the block is idle.
module ascii_hex_frame_encoder_top import ahfe_pkg::*; #(
  parameter int MAX_INFO_BYTES = 2047
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_command,
  input  wire logic [10:0] in_info_length,
  input  wire logic [7:0]  in_payload_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [6:0]       out_char,
  output logic             out_end_of_frame
);

  cfg_t   cfg_r;
  entry_t entry;
  entry_t head;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;
  logic   in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_acc    = in_valid && !q_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.version    <= 8'h00;
      cfg_r.address    <= 8'h00;
      cfg_r.class_code <= CLASS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_VERSION: cfg_r.version    <= cfg_data;
        REG_ADDRESS: cfg_r.address    <= cfg_data;
        REG_CLASS:   cfg_r.class_code <= cfg_data;
        default:     ;
      endcase
    end
  end

  ahfe_front #(
    .MAX_INFO_BYTES(MAX_INFO_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .command      (in_command),
    .info_length  (in_info_length),
    .payload_byte (in_payload_byte),
    .entry        (entry)
  );

  ahfe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .push_data (entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head)
  );

  ahfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_head    (head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_eof   (out_end_of_frame)
  );

endmodule

`default_nettype wire

// ===== rtl/ahfe_checker.sv =====
`default_nettype none

module ahfe_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [6:0] out_char,
  input wire logic       out_end_of_frame
);

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_end_of_frame))
    else $error("output beat changed while stalled");

  // The frame end flag sits on CR only.
  a_eof_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_frame |-> out_char == 7'h0D)
    else $error("end of frame not on CR");

  // Every character is a hex digit, the start mark or CR.
  a_charset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char >= 7'h30 && out_char <= 7'h39) ||
                  (out_char >= 7'h41 && out_char <= 7'h46) ||
                  out_char == 7'h7E || out_char == 7'h0D)
    else $error("character outside the frame alphabet");

  // CR always closes a frame.
  a_cr_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char == 7'h0D |-> out_end_of_frame)
    else $error("CR without end of frame");

  // Configuration writes are never held off.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind ascii_hex_frame_encoder_top ahfe_checker u_ahfe_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_char         (out_char),
  .out_end_of_frame (out_end_of_frame)
);

`default_nettype wire

// ===== bench/ahfe_frame_checker.sv =====
`default_nettype none

// Watches the configuration, input and character channels of the frame encoder.
// It rebuilds every frame from the accepted beats and compares each character
// that leaves the block with the oldest character still owed.
module ahfe_frame_checker import ahfe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  in_command,
  input  wire logic [10:0] in_info_length,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [6:0]  out_char,
  input  wire logic        out_end_of_frame,
  output int               mismatches,
  output int               chars_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // One character the block still owes, with its end-of-frame flag.
  typedef struct packed {
    logic [6:0] ch;
    logic       eof;
  } frame_char_t;

  frame_char_t due_q[$];
  int          fail_total = 0;
  int          due_count = 0;

  // Shadow copies of the header registers.
  logic [7:0]  hdr_version = 8'h00;
  logic [7:0]  hdr_address = 8'h00;
  logic [7:0]  hdr_class = CLASS_RESET;

  // Frame progress as the encoder should track it.
  logic        frame_open = 1'b0;
  logic [10:0] bytes_owed = '0;
  logic [15:0] running_sum = '0;

  assign mismatches = fail_total;
  assign chars_due  = due_count;

  task automatic report_mismatch(input string what);
    fail_total++;
    $display("%0t ahfe check: %s", $time, what);
  endtask

  // Uppercase ASCII digit of one nibble.
  function automatic logic [6:0] nibble_ascii(input logic [3:0] n);
    logic [6:0] c;
    if (n > 4'd9) c = 7'h41 + 7'(n - 4'd10);
    else          c = 7'h30 + 7'(n);
    return c;
  endfunction

  task automatic push_char(input logic [6:0] c, input logic eof);
    frame_char_t fc;
    fc.ch  = c;
    fc.eof = eof;
    due_q.push_back(fc);
  endtask

  // Two hex characters, high nibble first; both count toward the checksum.
  task automatic push_hex_byte(input logic [7:0] b);
    logic [6:0] c;
    c = nibble_ascii(b[7:4]);
    running_sum = running_sum + 16'(c);
    push_char(c, 1'b0);
    c = nibble_ascii(b[3:0]);
    running_sum = running_sum + 16'(c);
    push_char(c, 1'b0);
  endtask

  // Negated character sum as four hex digits, then CR closes the frame.
  task automatic push_trailer();
    logic [15:0] chk;
    chk = 16'd0 - running_sum;
    push_char(nibble_ascii(chk[15:12]), 1'b0);
    push_char(nibble_ascii(chk[11:8]), 1'b0);
    push_char(nibble_ascii(chk[7:4]), 1'b0);
    push_char(nibble_ascii(chk[3:0]), 1'b0);
    push_char(CHAR_CR, 1'b1);
    frame_open  = 1'b0;
    bytes_owed  = '0;
    running_sum = '0;
  endtask

  // Characters caused by one accepted input beat.
  task automatic encode_beat(input logic [7:0] cmd, input logic [10:0] len,
                             input logic [7:0] pb);
    logic [11:0] lenid;
    logic [3:0]  nsum;
    logic [3:0]  chk_nib;
    logic [15:0] word;
    if (!frame_open) begin
      // The 11-bit field cannot exceed the largest length, so no clamp applies.
      lenid   = {len, 1'b0};
      nsum    = lenid[3:0] + lenid[7:4] + lenid[11:8];
      chk_nib = 4'd0 - nsum;
      word    = {chk_nib, lenid};
      running_sum = '0;
      push_char(CHAR_SOF, 1'b0);
      push_hex_byte(hdr_version);
      push_hex_byte(hdr_address);
      push_hex_byte(hdr_class);
      push_hex_byte(cmd);
      push_hex_byte(word[15:8]);
      push_hex_byte(word[7:0]);
      if (len == '0) begin
        push_trailer();
        return;
      end
      frame_open = 1'b1;
      bytes_owed = len;
    end
    push_hex_byte(pb);
    if (bytes_owed != '0) bytes_owed = bytes_owed - 11'd1;
    if (bytes_owed == '0) push_trailer();
  endtask

  // Sample all three channels at the clock edge.
  always @(posedge clk) begin : monitor
    frame_char_t got;
    if (!rst_n) begin
      hdr_version = 8'h00;
      hdr_address = 8'h00;
      hdr_class   = CLASS_RESET;
      frame_open  = 1'b0;
      bytes_owed  = '0;
      running_sum = '0;
      due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_VERSION: hdr_version = cfg_data;
          REG_ADDRESS: hdr_address = cfg_data;
          REG_CLASS:   hdr_class = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) encode_beat(in_command, in_info_length, in_payload_byte);
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          report_mismatch($sformatf("char %h with nothing owed", out_char));
        end else begin
          got = due_q.pop_front();
          if (out_char !== got.ch)
            report_mismatch($sformatf("out_char %h, wanted %h", out_char, got.ch));
          if (out_end_of_frame !== got.eof)
            report_mismatch($sformatf("out_end_of_frame %b, wanted %b",
                                      out_end_of_frame, got.eof));
        end
      end
    end
    due_count <= due_q.size();
  end

endmodule

`default_nettype wire

// ===== bench/ascii_hex_frame_encoder_top_tb.sv =====
`default_nettype none

module ascii_hex_frame_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ahfe_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_VERSION;
  logic [7:0]  cfg_data = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_command = 8'h00;
  logic [10:0] in_info_length = '0;
  logic [7:0]  in_payload_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  out_char;
  logic        out_end_of_frame;

  int mismatches;
  int chars_due;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  ascii_hex_frame_encoder_top dut (.*);

  ahfe_frame_checker u_checker (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver side: stall at random at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Give up when no channel has moved a beat for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("ascii_hex_frame_encoder_top_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Byte with extra weight on both extremes.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(3))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  // Writes all header registers plus the unused index, valid held high throughout.
  task automatic program_regs(input logic [7:0] ver, input logic [7:0] addr,
                              input logic [7:0] cls);
    logic [1:0] idx [4];
    logic [7:0] vals [4];
    idx  = '{REG_VERSION, REG_ADDRESS, REG_CLASS, REG_UNUSED};
    vals = '{ver, addr, cls, 8'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // One input beat, after a random run of idle cycles.
  task automatic send_beat(input logic [7:0] cmd, input logic [10:0] len,
                           input logic [7:0] pb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_info_length  <= len;
    in_payload_byte <= pb;
    do @(posedge clk); while (!in_ready);
  endtask

  // A whole frame; later beats carry noise in the fields the block ignores.
  task automatic send_frame(input logic [7:0] cmd, input logic [10:0] len,
                            input int fill);
    int         beats;
    logic [7:0] pb;
    beats = (len == '0) ? 1 : int'(len);
    for (int i = 0; i < beats; i++) begin
      pb = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i == 0) send_beat(cmd, len, pb);
      else        send_beat(8'($urandom), 11'($urandom), pb);
    end
  endtask

  // Hold the sender until every owed character has left the block.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (chars_due != 0);
  endtask

  // Random frames, mostly short, under one idling pattern.
  task automatic run_random_phase(input int send_pct, input int stall_pct,
                                  input int n_items);
    int sent;
    int len;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    program_regs(pick_byte(), pick_byte(), pick_byte());
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) len = $urandom_range(40, 7);
      else                        len = $urandom_range(6);
      send_frame(pick_byte(), 11'(len), -1);
      sent += (len == 0) ? 1 : len;
      if ($urandom_range(7) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values, header-only and one-byte frames, extreme bytes.
    send_frame(8'h00, 11'd0, -1);
    send_frame(8'hFF, 11'd1, 8'hFF);
    send_frame(8'h5A, 11'd1, 8'h00);
    send_frame(8'hA5, 11'd2, -1);
    send_frame(8'h3C, 11'd3, -1);
    wait_drained();

    // All-ones header registers.
    program_regs(8'hFF, 8'hFF, 8'hFF);
    send_frame(8'hFF, 11'd0, -1);
    send_frame(8'h00, 11'd2, 8'hFF);
    wait_drained();

    // All-zero header registers.
    program_regs(8'h00, 8'h00, 8'h00);
    send_frame(8'h00, 11'd1, 8'h00);
    send_frame(8'h81, 11'd4, -1);
    wait_drained();

    // Length 23 gives a length id whose nibbles sum to 16, so the check nibble
    // is zero. A longer frame of all-ones bytes follows.
    program_regs(pick_byte(), pick_byte(), pick_byte());
    send_frame(8'($urandom), 11'd23, -1);
    send_frame(8'($urandom), 11'd60, 8'hFF);
    wait_drained();

    run_random_phase(0, 0, 30);
    run_random_phase(79, 0, 30);
    run_random_phase(0, 79, 30);
    run_random_phase(26, 26, 30);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ascii_hex_frame_encoder_top_tb: done, clean");
    end else begin
      $display("ascii_hex_frame_encoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== ascii_hex_frame_encoder_top.f =====
rtl/ahfe_pkg.sv
rtl/ahfe_front.sv
rtl/ahfe_queue.sv
rtl/ahfe_back.sv
rtl/ascii_hex_frame_encoder_top.sv
rtl/ahfe_checker.sv
bench/ahfe_frame_checker.sv
bench/ascii_hex_frame_encoder_top_tb.sv
